FILE: hw/rtl/split_direct_mapped_score_cache_core_assert.svh
// Assertion macros for the split direct-mapped score cache.
`ifndef SPLIT_DIRECT_MAPPED_SCORE_CACHE_CORE_ASSERT_SVH
`define SPLIT_DIRECT_MAPPED_SCORE_CACHE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on clk and ignored while rst is high.
`define SDMSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on clk and ignored while rst is high.
`define SDMSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SDMSC_ASSERT_IMP(lbl, ante, cons, msg)
`define SDMSC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/sdmsc_pkg.sv
// Shared types and constants of the split direct-mapped score cache.
`timescale 1ns / 1ps

package sdmsc_pkg;

  localparam int TABLE_DEPTH = 65536;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int HALF_LIMIT  = TABLE_DEPTH / 2;

  localparam int SIG_W   = 64;
  localparam int SCORE_W = 16;
  localparam int HALF_W  = 16;
  localparam int OP_W    = 2;
  localparam int CNT_W   = $clog2(SIG_W);

  localparam logic [HALF_W-1:0] HALF_RESET = 16'd32749;

  localparam logic [OP_W-1:0] OP_PROBE = 2'd0;
  localparam logic [OP_W-1:0] OP_STORE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [SIG_W-1:0]   sig_t;
  typedef logic [SCORE_W-1:0] score_t;
  typedef logic [HALF_W-1:0]  half_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  // One table entry as held in the memory.
  typedef struct packed {
    score_t score;
    sig_t   tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: hw/rtl/sdmsc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module sdmsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/split_direct_mapped_score_cache_core.sv
// Top level of the split direct-mapped score cache.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                       Payload
//  s_axis    in         s_axis_tvalid / s_axis_tready   tdata: signature, new_score
//                                                       tuser: opcode, black_to_move
//  m_axis    out        m_axis_tvalid / m_axis_tready   tdata: found_score
//                                                       tuser: hit
//  cfg       in         cfg_wr_en (no back-pressure)    cfg_wr_data: half_entries
//
// A probe passes through the remainder unit, a memory read and a tag compare before
// its result word, and a store through the remainder unit and a table write; the
// restoring remainder unit folds one signature bit per cycle. The unused opcode goes
// straight to the result state. The next word can be taken in the cycle after a
// result is handed over. A clear sweeps every table entry at one entry per cycle
// and then hands over its result word. After reset the same sweep runs with
// s_axis_tready low; configuration writes are taken throughout. A finished result
// sits in the output register, so the next word may be accepted while m_axis is
// stalled; a later result waits for that register.
`include "split_direct_mapped_score_cache_core_assert.svh"

module split_direct_mapped_score_cache_core (
  input  logic        clk,
  input  logic        rst,
  // Input words.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // [63:0] signature, [79:64] new_score
  input  logic [2:0]  s_axis_tuser,   // [1:0] opcode, [2] black_to_move
  // Result words.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] found_score
  output logic [0:0]  m_axis_tuser,   // [0] hit
  // Configuration: half_entries.
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  // One-hot sequencer states.
  typedef enum logic [6:0] {
    ST_SWEEP  = 7'b0000001,  // writing zeros through the whole table
    ST_IDLE   = 7'b0000010,  // waiting for an input word
    ST_DIV    = 7'b0000100,  // reducing the signature modulo the half size
    ST_WRITE  = 7'b0001000,  // store: writing the entry
    ST_READ   = 7'b0010000,  // probe: issuing the memory read
    ST_CMP    = 7'b0100000,  // probe: comparing the returned tag
    ST_RESULT = 7'b1000000   // handing the result to the output register
  } state_t;

  state_t state;

  // Configuration register.
  sdmsc_pkg::half_t half_entries;

  // Latched input word.
  logic [sdmsc_pkg::OP_W-1:0] op;
  logic                       black;
  sdmsc_pkg::sig_t            sig_reg;
  sdmsc_pkg::score_t          score_reg;

  // Remainder unit.
  sdmsc_pkg::addr_t rem;
  sdmsc_pkg::addr_t rem_next;
  sdmsc_pkg::addr_t rem_shift;
  sdmsc_pkg::cnt_t  bit_cnt;
  sdmsc_pkg::addr_t eff_half;
  sdmsc_pkg::addr_t slot;

  // Clearing sweep.
  sdmsc_pkg::addr_t sweep_addr;
  logic             clr_owed;

  // Pending result.
  logic              res_hit;
  sdmsc_pkg::score_t res_score;

  // Memory port signals.
  logic                ram_we;
  sdmsc_pkg::addr_t    ram_waddr;
  sdmsc_pkg::entry_t   ram_wdata;
  logic                ram_re;
  sdmsc_pkg::entry_t   ram_rdata;
  logic [sdmsc_pkg::ENTRY_W-1:0] ram_rdata_raw;

  logic in_accept;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Effective half size: zero behaves as one, and anything above half the
  // table is held to half the table so every slot stays in range.
  always_comb begin
    if (half_entries == '0) begin
      eff_half = sdmsc_pkg::addr_t'(1);
    end else if (32'(half_entries) > 32'(sdmsc_pkg::HALF_LIMIT)) begin
      eff_half = sdmsc_pkg::addr_t'(sdmsc_pkg::HALF_LIMIT);
    end else begin
      eff_half = sdmsc_pkg::addr_t'(half_entries);
    end
  end

  // One restoring step: bring in the next signature bit, MSB first, and
  // subtract the modulus once if the partial remainder reaches it. The
  // remainder stays below the modulus, so its top bit is always clear.
  assign rem_shift = {rem[sdmsc_pkg::ADDR_W-2:0], sig_reg[sdmsc_pkg::SIG_W-1]};

  always_comb begin
    if (rem_shift >= eff_half) begin
      rem_next = rem_shift - eff_half;
    end else begin
      rem_next = rem_shift;
    end
  end

  // The black half sits directly above the white half.
  assign slot = black ? (rem + eff_half) : rem;

  // Memory access selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot;
    ram_wdata = '{score: score_reg, tag: sig_reg};
    ram_re    = 1'b0;
    case (state)
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_addr;
        ram_wdata = '0;
      end
      ST_WRITE: begin
        ram_we = 1'b1;
      end
      ST_READ: begin
        ram_re = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  sdmsc_ram #(
    .WIDTH (sdmsc_pkg::ENTRY_W),
    .DEPTH (sdmsc_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (slot),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = sdmsc_pkg::entry_t'(ram_rdata_raw);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_entries <= sdmsc_pkg::HALF_RESET;
    end else if (cfg_wr_en) begin
      half_entries <= cfg_wr_data;
    end
  end

  // Input word capture and datapath registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op        <= s_axis_tuser[1:0];
      black     <= s_axis_tuser[2];
      sig_reg   <= s_axis_tdata[63:0];
      score_reg <= s_axis_tdata[79:64];
      rem       <= '0;
    end else if (state == ST_DIV) begin
      // Rotating the signature leaves it whole again after the last bit,
      // ready for the tag write or compare.
      sig_reg <= {sig_reg[sdmsc_pkg::SIG_W-2:0], sig_reg[sdmsc_pkg::SIG_W-1]};
      rem     <= rem_next;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_SWEEP;
      sweep_addr    <= '0;
      clr_owed      <= 1'b0;
      bit_cnt       <= '0;
      res_hit       <= 1'b0;
      res_score     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // The output register is refilled when the result is handed over and
      // emptied when the receiver takes its word.
      if (state == ST_RESULT && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        ST_SWEEP: begin
          sweep_addr <= sweep_addr + sdmsc_pkg::addr_t'(1);
          if (sweep_addr == '1) begin
            state    <= clr_owed ? ST_RESULT : ST_IDLE;
            clr_owed <= 1'b0;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            res_hit   <= 1'b0;
            res_score <= '0;
            bit_cnt   <= '0;
            if (s_axis_tuser[1:0] == sdmsc_pkg::OP_PROBE ||
                s_axis_tuser[1:0] == sdmsc_pkg::OP_STORE) begin
              state <= ST_DIV;
            end else if (s_axis_tuser[1:0] == sdmsc_pkg::OP_CLEAR) begin
              state      <= ST_SWEEP;
              sweep_addr <= '0;
              clr_owed   <= 1'b1;
            end else begin
              // The unused opcode changes nothing and answers a miss.
              state <= ST_RESULT;
            end
          end
        end
        ST_DIV: begin
          bit_cnt <= bit_cnt + sdmsc_pkg::cnt_t'(1);
          if (bit_cnt == '1) begin
            state <= (op == sdmsc_pkg::OP_STORE) ? ST_WRITE : ST_READ;
          end
        end
        ST_WRITE: begin
          state <= ST_RESULT;
        end
        ST_READ: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          // A hit needs the full signature to match the stored tag.
          if (ram_rdata.tag == sig_reg) begin
            res_hit   <= 1'b1;
            res_score <= ram_rdata.score;
          end
          state <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_SWEEP;
        end
      endcase
    end
  end

  // Output payload register; loaded only when the result is handed over.
  always_ff @(posedge clk) begin
    if (state == ST_RESULT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= res_score;
      m_axis_tuser <= res_hit;
    end
  end

  // The table is written only by the clearing sweep and by a store.
  `SDMSC_ASSERT_IMP(a_write_source, ram_we, (state == ST_SWEEP || state == ST_WRITE),
                    "table written outside a sweep or a store")
  // No input word is taken while the table is being cleared.
  `SDMSC_ASSERT_IMP(a_no_accept_sweep, state == ST_SWEEP, !s_axis_tready,
                    "input accepted during the clearing sweep")
  // A miss, a store or a clear always reports a zero score.
  `SDMSC_ASSERT_IMP(a_miss_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0,
                    "result without a hit carries a non-zero score")
  // The remainder unit finishes after the last signature bit.
  `SDMSC_ASSERT_NXT(a_div_done, state == ST_DIV && bit_cnt == '1,
                    (state == ST_READ || state == ST_WRITE),
                    "remainder unit did not hand over after the last bit")

endmodule
